FILE: rtl/core/tcw_pkg.sv
// Shared constants, types and state codes of the text console writer.
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 24;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int CUR_W  = 11;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int CODE_W = 9;
   localparam int BYTE_W = 8;
   localparam int CELL_W = 16;
   localparam int SEQ_W  = 2;

   localparam int REQ_DATA_W = ((CODE_W + CUR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BYTE_W + CUR_W + CELL_W + 7) / 8) * 8;

   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
   localparam logic [CODE_W-1:0] CODE_LEFT      = 9'd228;
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;

   localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] ATTR       = 8'h07;

   localparam logic [CUR_W-1:0] CUR_CELLS    = CUR_W'(CELLS);
   localparam logic [CUR_W-1:0] CUR_LAST     = CUR_W'(CELLS - 1);
   localparam logic [CUR_W-1:0] CUR_LAST_ROW = CUR_W'(CELLS - COLUMNS);
   localparam logic [CUR_W-1:0] CUR_COLS     = CUR_W'(COLUMNS);
   localparam logic [COL_W-1:0] COL_LAST     = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(ROWS - 1);
   localparam logic [SEQ_W-1:0] SEQ_BS_LAST  = 2'd2;
   localparam logic [SEQ_W-1:0] SEQ_BS_SPACE = 2'd1;

   typedef struct packed {
      logic              en;
      logic [CUR_W-1:0]  addr;
      logic [CELL_W-1:0] data;
   } tcw_wr_type;

   typedef struct packed {
      logic             en;
      logic [CUR_W-1:0] addr;
   } tcw_rd_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_RDWAIT = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_SCROLL = 5'b10000
   } tcw_state_type;

endpackage

FILE: rtl/core/text_console_writer.sv
// Text console writer top level: cursor, cell store sequencer and result stage.
// A put goes to EMIT, which registers its result; a read first waits in RDWAIT for the cell data.
// A new request is taken only in IDLE, after every result of the previous one and any scroll.
// A put that scrolls then copies the cells up one row and clears the bottom row through the RAM ports.
// Reset is synchronous; afterwards the cell store is cleared to zero cell by cell, with req_tready low.
module text_console_writer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // char_code[8:0], cell_index[19:9], zero fill
   input  logic [tcw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // serial_byte[7:0], cursor_position[18:8], cell_value[34:19], zero fill
   output logic [tcw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // has_serial
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import tcw_pkg::*;

   tcw_state_type     state_ff, state_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CUR_W-1:0]  cnt_ff, cnt_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic              scroll_ff, scroll_in;
   logic              is_bs_ff, is_bs_in;
   logic              is_rd_ff, is_rd_in;
   logic              rd_zero_ff, rd_zero_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   tcw_wr_type        wr;
   tcw_rd_type        rd;
   logic [CELL_W-1:0] rd_data;

   logic [CODE_W-1:0] code;
   logic [CUR_W-1:0]  index;
   logic              accept;
   logic              out_free;
   logic              res_has;
   logic [BYTE_W-1:0] res_byte;
   logic              res_last;
   logic [CELL_W-1:0] res_cell;

   tcw_cell_ram u_cell_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign code       = req_tdata[CODE_W-1:0];
   assign index      = req_tdata[CODE_W+CUR_W-1:CODE_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      res_has  = 1'b1;
      res_byte = byte_ff;
      res_last = 1'b1;
      res_cell = '0;
      if (is_rd_ff) begin
         res_has  = 1'b0;
         res_byte = '0;
         res_cell = cell_ff;
      end else if (is_bs_ff) begin
         res_byte = (seq_ff == SEQ_BS_SPACE) ? BYTE_SPACE : BYTE_BS;
         res_last = (seq_ff == SEQ_BS_LAST);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      cnt_in      = cnt_ff;
      seq_in      = seq_ff;
      scroll_in   = scroll_ff;
      is_bs_in    = is_bs_ff;
      is_rd_in    = is_rd_ff;
      rd_zero_in  = rd_zero_ff;
      byte_in     = byte_ff;
      cell_in     = cell_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      rsp_data_in = rsp_data_ff;
      wr          = '0;
      rd          = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = cnt_ff;
            wr.data = '0;
            cnt_in  = cnt_ff + CUR_W'(1);
            if (cnt_ff == CUR_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               seq_in    = '0;
               scroll_in = 1'b0;
               is_bs_in  = 1'b0;
               is_rd_in  = 1'b0;
               byte_in   = code[BYTE_W-1:0];
               state_in  = ST_EMIT;
               if (req_tuser == KIND_READ) begin
                  is_rd_in   = 1'b1;
                  rd.en      = 1'b1;
                  rd.addr    = index;
                  rd_zero_in = (index >= CUR_CELLS);
                  state_in   = ST_RDWAIT;
               end else if (code == CODE_BACKSPACE || code == CODE_LEFT) begin
                  byte_in  = BYTE_BS;
                  is_bs_in = (code == CODE_BACKSPACE);
                  if (cursor_ff != '0) begin
                     cursor_in = cursor_ff - CUR_W'(1);
                     if (col_ff == '0) begin
                        col_in = COL_LAST;
                        row_in = row_ff - ROW_W'(1);
                     end else begin
                        col_in = col_ff - COL_W'(1);
                     end
                  end
                  wr.en   = (code == CODE_BACKSPACE);
                  wr.addr = cursor_in;
                  wr.data = {ATTR, BYTE_SPACE};
               end else begin
                  if (code != CODE_NEWLINE) begin
                     wr.en   = 1'b1;
                     wr.addr = cursor_ff;
                     wr.data = {ATTR, code[BYTE_W-1:0]};
                  end
                  if (code == CODE_NEWLINE || col_ff == COL_LAST) begin
                     col_in = '0;
                     if (row_ff == ROW_LAST) begin
                        cursor_in = CUR_LAST_ROW;
                        scroll_in = 1'b1;
                     end else begin
                        row_in    = row_ff + ROW_W'(1);
                        cursor_in = cursor_ff + CUR_COLS - CUR_W'(col_ff);
                     end
                  end else begin
                     col_in    = col_ff + COL_W'(1);
                     cursor_in = cursor_ff + CUR_W'(1);
                  end
               end
            end
         end
         ST_RDWAIT: begin
            cell_in  = rd_zero_ff ? '0 : rd_data;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_has;
               rsp_last_in  = res_last;
               rsp_data_in  = RSP_DATA_W'({res_cell, cursor_ff, res_byte});
               seq_in       = seq_ff + SEQ_W'(1);
               if (res_last) begin
                  cnt_in   = '0;
                  state_in = scroll_ff ? ST_SCROLL : ST_IDLE;
               end
            end
         end
         ST_SCROLL: begin
            rd.en   = (cnt_ff < CUR_LAST_ROW);
            rd.addr = cnt_ff + CUR_COLS;
            wr.en   = (cnt_ff != '0);
            wr.addr = cnt_ff - CUR_W'(1);
            wr.data = (cnt_ff <= CUR_LAST_ROW) ? rd_data : '0;
            cnt_in  = cnt_ff + CUR_W'(1);
            if (cnt_ff == CUR_CELLS) begin
               cnt_in    = '0;
               scroll_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cursor_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         seq_ff       <= '0;
         scroll_ff    <= 1'b0;
         is_bs_ff     <= 1'b0;
         is_rd_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         seq_ff       <= seq_in;
         scroll_ff    <= scroll_in;
         is_bs_ff     <= is_bs_in;
         is_rd_ff     <= is_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_zero_ff  <= rd_zero_in;
      byte_ff     <= byte_in;
      cell_ff     <= cell_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/tcw_cell_ram.sv
// Screen cell store: one write port, one read port with registered read data.
module tcw_cell_ram (
   input  logic                           clock,
   input  tcw_pkg::tcw_wr_type            wr,
   input  tcw_pkg::tcw_rd_type            rd,
   output logic [tcw_pkg::CELL_W-1:0]     rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] cell_mem_ff [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cell_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= cell_mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
